[src/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants for the multilevel queue
// Sizes, status codes, and the command word passed from front to back.
// ----------------------------------------------------------------------------
package mlfq_pkg;
	localparam int LEVELS = 8;
	localparam int FIFO_DEPTH = 16;
	localparam int ITEM_WIDTH = 32;
	localparam int LVL_W = 3;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int TOT_W = 8;
	localparam int ADDR_W = $clog2(LEVELS * FIFO_DEPTH);
	localparam int CMDQ_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LEVEL = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	// One classified command: bad-level words need no back-end lookup.
	typedef struct packed {
		op_t                   op;
		logic                  bad;
		logic [LVL_W-1:0]      lvl;
		logic [ITEM_WIDTH-1:0] data;
	} cmd_t;
endpackage

[src/mlfq_ram.sv]
// ----------------------------------------------------------------------------
// mlfq_ram: generic single-port-write, single-port-read RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module mlfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/mlfq_front.sv]
// ----------------------------------------------------------------------------
// mlfq_front: input classification and command queue
// Checks the level against the levels in use and buffers commands for the back.
// ----------------------------------------------------------------------------
module mlfq_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           opcode,
	input  logic [mlfq_pkg::LVL_W-1:0]     level,
	input  logic [mlfq_pkg::ITEM_WIDTH-1:0] item_data,
	input  logic [3:0]                     level_count,
	output mlfq_pkg::cmd_t                 cmd,
	output logic                           cmd_valid,
	input  logic                           cmd_take
);
	import mlfq_pkg::*;

	cmd_t            q_q [CMDQ_DEPTH];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic [4:0]      in_use;
	cmd_t            cin;
	logic            do_push, do_pop;

	always_comb begin
		in_use = (level_count > 4'(LEVELS)) ? 5'(LEVELS) : {1'b0, level_count};
		cin.op = op_t'(opcode);
		cin.bad = {2'b00, level} >= in_use;
		cin.lvl = level;
		cin.data = item_data;
	end

	assign full = cnt_q == 2'(CMDQ_DEPTH);
	assign do_push = push && !full;
	assign do_pop = cmd_take && cmd_valid;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wp_q] <= cin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(CMDQ_DEPTH)) else $error("command queue overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !do_pop) else $error("pop from empty command queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("command count mismatch");
`endif
endmodule

[src/mlfq_back.sv]
// ----------------------------------------------------------------------------
// mlfq_back: level bookkeeping, rotating search and result register
// Executes each command as decide and access, then answer.
// ----------------------------------------------------------------------------
module mlfq_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mlfq_pkg::cmd_t                   cmd,
	input  logic                             cmd_valid,
	output logic                             cmd_take,
	input  logic [3:0]                       level_count,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       status,
	output logic [mlfq_pkg::LVL_W-1:0]       found_level,
	output logic [mlfq_pkg::ITEM_WIDTH-1:0]  item_out,
	output logic [mlfq_pkg::TOT_W-1:0]       total_length
);
	import mlfq_pkg::*;

	logic [PTR_W-1:0]  head_q [LEVELS];
	logic [PTR_W-1:0]  tail_q [LEVELS];
	logic [FILL_W-1:0] fill_q [LEVELS];
	logic [TOT_W-1:0]  total_q;

	logic              busy_s1;
	logic [1:0]        st_s1;
	logic [LVL_W-1:0]  lvl_s1;
	logic              rd_s1;
	logic [TOT_W-1:0]  tot_s1;

	logic              out_v_q;
	logic [1:0]        st_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [ITEM_WIDTH-1:0] item_q;
	logic [TOT_W-1:0]  tot_q;

	logic [4:0]        in_use;
	logic [LEVELS-1:0] nz;
	logic              hit;
	logic [LVL_W-1:0]  hit_lvl;
	logic              go;
	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [ITEM_WIDTH-1:0] rdata;
	logic [1:0]        st_n;
	logic [4:0]        idx;

	// A new command starts only when stage one is free and the result slot is free or being popped.
	assign go = cmd_valid && !busy_s1 && (!out_v_q || pop);
	assign cmd_take = go;

	always_comb begin
		in_use = (level_count > 4'(LEVELS)) ? 5'(LEVELS) : {1'b0, level_count};
		for (int i = 0; i < LEVELS; i++) begin
			nz[i] = (fill_q[i] != '0) && (5'(i) < in_use);
		end
		// Rotating priority search from the starting level upward.
		hit = 1'b0;
		hit_lvl = '0;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			idx = 5'(cmd.lvl) + 5'(k);
			if (idx >= in_use) idx = idx - in_use;
			if (nz[idx[LVL_W-1:0]]) begin
				hit = 1'b1;
				hit_lvl = idx[LVL_W-1:0];
			end
		end
		we = 1'b0;
		st_n = ST_OK;
		if (cmd.bad) begin
			st_n = ST_BAD_LEVEL;
		end else if (cmd.op == OP_ENQ) begin
			if (fill_q[cmd.lvl] == FILL_W'(FIFO_DEPTH)) st_n = ST_FULL;
			else we = go;
		end else if (!hit) begin
			st_n = ST_EMPTY;
		end
		waddr = ADDR_W'({cmd.lvl, tail_q[cmd.lvl]});
		raddr = ADDR_W'({hit_lvl, head_q[hit_lvl]});
	end

	mlfq_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(LEVELS * FIFO_DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(cmd.data),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			total_q <= '0;
			busy_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && pop) out_v_q <= 1'b0;
			busy_s1 <= go;
			if (go && st_n == ST_OK) begin
				if (cmd.op == OP_ENQ) begin
					tail_q[cmd.lvl] <= tail_q[cmd.lvl] + 1'b1;
					fill_q[cmd.lvl] <= fill_q[cmd.lvl] + 1'b1;
					total_q <= total_q + 1'b1;
				end else begin
					head_q[hit_lvl] <= head_q[hit_lvl] + 1'b1;
					fill_q[hit_lvl] <= fill_q[hit_lvl] - 1'b1;
					total_q <= total_q - 1'b1;
				end
			end
			if (busy_s1) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			st_s1 <= st_n;
			rd_s1 <= (cmd.op == OP_DEQ) && (st_n == ST_OK);
			lvl_s1 <= (cmd.op == OP_DEQ && st_n == ST_OK) ? hit_lvl : '0;
			if (st_n != ST_OK) tot_s1 <= total_q;
			else if (cmd.op == OP_ENQ) tot_s1 <= total_q + 1'b1;
			else tot_s1 <= total_q - 1'b1;
		end
		if (busy_s1) begin
			st_q <= st_s1;
			lvl_q <= lvl_s1;
			item_q <= rd_s1 ? rdata : '0;
			tot_q <= tot_s1;
		end
	end

	assign empty = !out_v_q;
	assign status = st_q;
	assign found_level = lvl_q;
	assign item_out = item_q;
	assign total_length = tot_q;

`ifndef SYNTH
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !out_v_q || pop) else $error("result slot overrun");
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !go) else $error("two commands in flight");
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(LEVELS * FIFO_DEPTH)) else $error("total count overflow");
`endif
endmodule

[src/multilevel_fifo_rotating_dequeue.sv]
// ----------------------------------------------------------------------------
// multilevel_fifo_rotating_dequeue: per-level FIFOs with rotating dequeue
// Front classifies words into a command queue, back executes them.
// ----------------------------------------------------------------------------
// A word pushed into an idle block is registered in the command queue, then in
// stage one, then in the result register. The back end takes no new word while
// one is in stage one, nor while the result slot is full and not being popped.
// Reset: asynchronous; all levels empty, total zero, level_count 8.
// The item store itself is not cleared; only written entries are ever read.
module multilevel_fifo_rotating_dequeue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        opcode,
	input  logic [2:0]  level,
	input  logic [31:0] item_data,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [2:0]  found_level,
	output logic [31:0] item_out,
	output logic [7:0]  total_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mlfq_pkg::*;

	logic [3:0] level_count_q;
	cmd_t       cmd;
	logic       cmd_valid, cmd_take;

	assign pready = 1'b1;
	assign prdata = paddr ? 32'd0 : {28'd0, level_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= 4'(LEVELS);
		end else if (psel && penable && pwrite && !paddr) begin
			level_count_q <= pwdata[3:0];
		end
	end

	mlfq_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .level(level), .item_data(item_data),
		.level_count(level_count_q), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take)
	);

	mlfq_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .level_count(level_count_q), .empty(empty),
		.pop(pop), .status(status), .found_level(found_level),
		.item_out(item_out), .total_length(total_length)
	);
endmodule

[tb/sv/mlfq_checker.sv]
// ----------------------------------------------------------------------------
// mlfq_checker: result predictor and scoreboard for the multilevel queue
// Snoops accepted words and register writes, predicts each result from its
// own copy of the per-level FIFOs and compares the results as they are popped.
// ----------------------------------------------------------------------------
module mlfq_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        opcode,
	input  logic [2:0]  level,
	input  logic [31:0] item_data,
	input  logic        empty,
	input  logic        pop,
	input  logic [1:0]  status,
	input  logic [2:0]  found_level,
	input  logic [31:0] item_out,
	input  logic [7:0]  total_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending_count
);
	import mlfq_pkg::*;

	typedef struct packed {
		status_t          st;
		logic [LVL_W-1:0] lvl;
		logic [31:0]      word;
		logic [TOT_W-1:0] total;
	} answer_t;

	logic [ITEM_WIDTH-1:0] model_store [LEVELS][FIFO_DEPTH];
	logic [PTR_W-1:0]      model_head [LEVELS];
	logic [PTR_W-1:0]      model_tail [LEVELS];
	logic [FILL_W-1:0]     model_fill [LEVELS];
	logic [TOT_W-1:0]      model_total;
	logic [3:0]            model_lvl_count;
	answer_t               answers_due[$];

	assign pending_count = answers_due.size();

	task automatic predict_answer(input op_t op, input logic [2:0] lvl_in,
		input logic [31:0] data);
		int      in_use;
		int      lvl;
		answer_t a;
		in_use = (model_lvl_count > LEVELS) ? LEVELS : model_lvl_count;
		lvl = lvl_in;
		a = '{st: ST_OK, lvl: '0, word: '0, total: '0};
		if (lvl >= in_use) begin
			a.st = ST_BAD_LEVEL;
		end else if (op == OP_ENQ) begin
			if (model_fill[lvl] >= FIFO_DEPTH) begin
				a.st = ST_FULL;
			end else begin
				model_store[lvl][model_tail[lvl]] = data;
				model_tail[lvl] = model_tail[lvl] + 1'b1;
				model_fill[lvl] = model_fill[lvl] + 1'b1;
				model_total = model_total + 1'b1;
			end
		end else begin
			a.st = ST_EMPTY;
			// Search upward from the start level, wrapping within the levels in use.
			for (int n = 0; n < in_use; n++) begin
				if (a.st == ST_EMPTY && model_fill[lvl] != 0) begin
					a.st = ST_OK;
					a.lvl = LVL_W'(lvl);
					a.word = model_store[lvl][model_head[lvl]];
					model_head[lvl] = model_head[lvl] + 1'b1;
					model_fill[lvl] = model_fill[lvl] - 1'b1;
					model_total = model_total - 1'b1;
				end
				lvl = (lvl + 1 >= in_use) ? 0 : lvl + 1;
			end
		end
		a.total = model_total;
		answers_due.push_back(a);
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				model_head[i] = '0;
				model_tail[i] = '0;
				model_fill[i] = '0;
			end
			model_total = '0;
			model_lvl_count = 4'd8;
			answers_due.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 1'b0)
				model_lvl_count = pwdata[3:0];
			if (push && !full)
				predict_answer(op_t'(opcode), level, item_data);
			if (pop && !empty) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected result word: st=%0d lvl=%0d",
						$time, status, found_level);
					$display("%0t: unexpected result word: data=%h tot=%0d",
						$time, item_out, total_length);
					fail_count++;
				end else begin
					a = answers_due.pop_front();
					if (status !== a.st) begin
						$display("%0t: status expected %0d actual %0d", $time, a.st, status);
						fail_count++;
					end
					if (found_level !== a.lvl) begin
						$display("%0t: found_level expected %0d actual %0d",
							$time, a.lvl, found_level);
						fail_count++;
					end
					if (item_out !== a.word) begin
						$display("%0t: item_out expected %h actual %h", $time, a.word, item_out);
						fail_count++;
					end
					if (total_length !== a.total) begin
						$display("%0t: total_length expected %0d actual %0d",
							$time, a.total, total_length);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

[tb/sv/tb_multilevel_fifo_rotating_dequeue.sv]
// ----------------------------------------------------------------------------
// tb_multilevel_fifo_rotating_dequeue: testbench top for the multilevel queue
// Drives directed and random enqueue/dequeue words across several level
// counts with random stalls on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_multilevel_fifo_rotating_dequeue;
	import mlfq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        opcode;
	logic [2:0]  level;
	logic [31:0] item_data;
	logic        empty;
	logic        pop;
	logic [1:0]  status;
	logic [2:0]  found_level;
	logic [31:0] item_out;
	logic [7:0]  total_length;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic        paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending_count;
	int          words_sent;
	int          words_taken;
	int          hold_req;
	bit          steady_send;
	int          lvl_in_use;

	multilevel_fifo_rotating_dequeue dut (.*);

	mlfq_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 600000);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady_send || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random pops, occasional long holds, and a hold on request.
	initial begin
		int hold;
		int r;
		pop = 1'b0;
		hold = 0;
		words_taken = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) words_taken++;
			if (hold_req > 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					pop <= 1'b1;
				end else if (r < 98) begin
					pop <= 1'b0;
				end else begin
					pop <= 1'b0;
					hold = $urandom_range(10, 50);
				end
			end
		end
	end

	task automatic send_word(input op_t op, input logic [2:0] lvl, input logic [31:0] data);
		int gap;
		push <= 1'b1;
		opcode <= op;
		level <= lvl;
		item_data <= data;
		do @(posedge clk); while (full);
		words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (words_taken != words_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_level_count(input logic [3:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 1'b0;
		pwdata <= {28'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		lvl_in_use = (value > LEVELS) ? LEVELS : value;
	endtask

	task automatic random_phase(input int n_words, input int enq_pct);
		logic [2:0] lvl;
		op_t        op;
		for (int i = 0; i < n_words; i++) begin
			op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
			if (lvl_in_use == 0 || $urandom_range(0, 9) == 0)
				lvl = 3'($urandom_range(0, 7));
			else
				lvl = 3'($urandom_range(0, lvl_in_use - 1));
			steady_send = (i % 100) >= 80;
			send_word(op, lvl, $urandom());
		end
		steady_send = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		opcode = 1'b0;
		level = '0;
		item_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 1'b0;
		pwdata = '0;
		words_sent = 0;
		hold_req = 0;
		steady_send = 1'b0;
		lvl_in_use = LEVELS;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: empty search, extreme data, wrap-round search, full level.
		send_word(OP_DEQ, 3'd0, 32'h0);
		send_word(OP_ENQ, 3'd7, 32'hFFFF_FFFF);
		send_word(OP_ENQ, 3'd0, 32'h0000_0000);
		send_word(OP_DEQ, 3'd5, 32'hFFFF_FFFF);
		send_word(OP_DEQ, 3'd5, 32'h0);
		for (int i = 0; i < 17; i++)
			send_word(OP_ENQ, 3'd3, 32'hA5A5_0000 + i);
		send_word(OP_DEQ, 3'd4, 32'h0);
		send_word(OP_DEQ, 3'd2, 32'h0);
		wait_drained();

		// Block fills up while the receiver is held off.
		hold_req = 300;
		random_phase(40, 80);
		wait_drained();

		random_phase(200, 70);
		random_phase(150, 40);
		wait_drained();
		// Fewer levels in use: items above stay counted but out of reach.
		write_level_count(4'd3);
		random_phase(150, 55);
		wait_drained();
		write_level_count(4'd0);
		random_phase(40, 50);
		wait_drained();
		write_level_count(4'd1);
		random_phase(130, 60);
		wait_drained();
		write_level_count(4'd15);
		random_phase(170, 45);
		wait_drained();
		write_level_count(4'd8);
		random_phase(150, 30);
		wait_drained();
		repeat (20) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

[filelist.f]
src/mlfq_pkg.sv
src/mlfq_ram.sv
src/mlfq_front.sv
src/mlfq_back.sv
src/multilevel_fifo_rotating_dequeue.sv
tb/sv/mlfq_checker.sv
tb/sv/tb_multilevel_fifo_rotating_dequeue.sv
